// ----- rtl/core/icne_pkg.sv -----
// Shared types and constants of the inverse-Collatz node expander.
`timescale 1ns / 1ps

package icne_pkg;

    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned DEPTH_W       = 12;
    localparam int unsigned TBL_DEPTH_DEF = 4096;

    localparam logic [VALUE_W-1:0] ALL_ONES        = '1;
    localparam logic [VALUE_W-1:0] THIRD_K         = 64'h5555_5555_5555_5555;
    localparam logic [VALUE_W-1:0] RANGE_LIMIT_RST = 64'd65536;

    typedef enum logic {
        CMD_EXPAND = 1'b0,
        CMD_LOAD   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        DISP_ACTIVE   = 2'd0,
        DISP_DEFERRED = 2'd1,
        DISP_PRUNED   = 2'd2
    } disp_t;

    typedef enum logic [1:0] {
        REG_RANGE_LIMIT = 2'd0,
        REG_VALUE_BOUND = 2'd1,
        REG_STEPS_BOUND = 2'd2
    } reg_idx_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [VALUE_W-1:0] node_value;
        logic [DEPTH_W-1:0] node_depth;
        logic [VALUE_W-1:0] table_word;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] child_value;
        logic [DEPTH_W-1:0] child_depth;
        disp_t              disposition;
        logic               last_child;
    } out_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctl_t;

    typedef struct packed {
        logic               odd_valid;
        logic [VALUE_W-1:0] odd_value;
        disp_t              odd_disp;
        logic [VALUE_W-1:0] even_value;
        disp_t              even_disp;
        logic [DEPTH_W-1:0] depth;
    } brood_t;

endpackage

// ----- rtl/core/icne_table.sv -----
// Growth threshold table: single-port-write, registered-read memory.
`timescale 1ns / 1ps

module icne_table #(
    parameter int unsigned TBL_DEPTH = icne_pkg::TBL_DEPTH_DEF
) (
    input  logic                              clk,
    input  icne_pkg::tbl_ctl_t                ctl,
    input  logic [$clog2(TBL_DEPTH)-1:0]      wr_addr,
    input  logic [icne_pkg::VALUE_W-1:0]      wr_data,
    input  logic [$clog2(TBL_DEPTH)-1:0]      rd_addr,
    output logic [icne_pkg::VALUE_W-1:0]      rd_data
);
    import icne_pkg::*;

    logic [VALUE_W-1:0] mem [TBL_DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/icne_datapath.sv -----
// Expansion pipeline: table access, residue, exact division by three and activity tests.
`timescale 1ns / 1ps

module icne_datapath #(
    parameter int unsigned TBL_DEPTH = icne_pkg::TBL_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  icne_pkg::in_item_t                in_data,
    input  logic [icne_pkg::VALUE_W-1:0]      range_limit,
    input  logic [icne_pkg::VALUE_W-1:0]      value_bound,
    input  logic [icne_pkg::DEPTH_W-1:0]      steps_bound,
    output icne_pkg::tbl_ctl_t                tbl_ctl,
    output logic [$clog2(TBL_DEPTH)-1:0]      tbl_wr_addr,
    output logic [icne_pkg::VALUE_W-1:0]      tbl_wr_data,
    output logic [$clog2(TBL_DEPTH)-1:0]      tbl_rd_addr,
    input  logic [icne_pkg::VALUE_W-1:0]      tbl_rd_data,
    output logic                              brood_valid,
    output icne_pkg::brood_t                  brood,
    input  logic                              brood_ready
);
    import icne_pkg::*;

    localparam int unsigned AW = $clog2(TBL_DEPTH);

    // Residue modulo three: base-four digits each weigh one.
    function automatic logic [1:0] mod3_64(input logic [VALUE_W-1:0] v);
        logic [3:0] grp [8];
        logic [6:0] tot;
        logic [3:0] fold;
        logic [1:0] res;
        for (int g = 0; g < 8; g++)
        begin
            grp[g] = 4'd0;
            for (int d = 0; d < 4; d++)
            begin
                grp[g] = grp[g] + 4'(v[g*8 + d*2 +: 2]);
            end
        end
        tot = 7'd0;
        for (int g = 0; g < 8; g++)
        begin
            tot = tot + 7'(grp[g]);
        end
        fold = 4'(tot[1:0]) + 4'(tot[3:2]) + 4'(tot[5:4]) + 4'(tot[6]);
        if (fold >= 4'd9)
            res = 2'(fold - 4'd9);
        else if (fold >= 4'd6)
            res = 2'(fold - 4'd6);
        else if (fold >= 4'd3)
            res = 2'(fold - 4'd3);
        else
            res = 2'(fold);
        return res;
    endfunction

    logic               accept;
    logic [DEPTH_W-1:0] in_cd;
    logic [DEPTH_W-1:0] in_r;
    logic               in_below;
    logic               in_rin;
    logic               rdy1;
    logic               rdy2;
    logic               rdy3;
    logic               rdy4;

    logic               s1_v_reg;
    logic [VALUE_W-1:0] s1_x_reg;
    logic [DEPTH_W-1:0] s1_cd_reg;
    logic               s1_below_reg;
    logic               s1_rin_reg;

    logic [1:0]         s1_m3;
    logic [VALUE_W-1:0] s1_a1;
    logic               s2_v_next;
    logic               s2_odd_next;
    logic [VALUE_W-1:0] s2_a2_next;
    logic               s2_unl_next;
    logic [VALUE_W-1:0] s2_lim_next;

    logic               s2_v_reg;
    logic [VALUE_W-1:0] s2_x_reg;
    logic [DEPTH_W-1:0] s2_cd_reg;
    logic               s2_odd_reg;
    logic [VALUE_W-1:0] s2_a2_reg;
    logic               s2_unl_reg;
    logic [VALUE_W-1:0] s2_lim_reg;

    logic [VALUE_W-1:0] s2_a3;
    logic [VALUE_W-1:0] s3_a4_next;
    logic [VALUE_W-1:0] s2_z;
    logic               s2_z_act;
    logic [VALUE_W-1:0] s3_zval_next;
    disp_t              s3_zdisp_next;

    logic               s3_v_reg;
    logic [DEPTH_W-1:0] s3_cd_reg;
    logic               s3_odd_reg;
    logic [VALUE_W-1:0] s3_a4_reg;
    logic               s3_unl_reg;
    logic [VALUE_W-1:0] s3_lim_reg;
    logic [VALUE_W-1:0] s3_zval_reg;
    disp_t              s3_zdisp_reg;

    logic [VALUE_W-1:0] s3_a5;
    logic [VALUE_W-1:0] s4_y_next;

    logic               s4_v_reg;
    logic [DEPTH_W-1:0] s4_cd_reg;
    logic               s4_odd_reg;
    logic [VALUE_W-1:0] s4_y_reg;
    logic               s4_unl_reg;
    logic [VALUE_W-1:0] s4_lim_reg;
    logic [VALUE_W-1:0] s4_zval_reg;
    disp_t              s4_zdisp_reg;

    logic               s4_y_act;

    // Handshake and table access at the input.
    assign rdy4     = !s4_v_reg || brood_ready;
    assign rdy3     = !s3_v_reg || rdy4;
    assign rdy2     = !s2_v_reg || rdy3;
    assign rdy1     = !s1_v_reg || rdy2;
    assign in_stall = !rdy1;
    assign accept   = in_valid && !in_stall;

    assign in_cd    = in_data.node_depth + 12'd1;
    assign in_below = in_cd < steps_bound;
    assign in_r     = steps_bound - in_cd;
    assign in_rin   = 32'(in_r) < 32'(TBL_DEPTH);

    assign tbl_ctl.rd_en = accept && (in_data.cmd == CMD_EXPAND);
    assign tbl_ctl.wr_en = accept && (in_data.cmd == CMD_LOAD)
                           && (32'(in_data.node_depth) < 32'(TBL_DEPTH));
    assign tbl_rd_addr   = AW'(in_r);
    assign tbl_wr_addr   = AW'(in_data.node_depth);
    assign tbl_wr_data   = in_data.table_word;

    // Stage one: residue, first steps of the product by the third constant, limit.
    always_comb
    begin
        s1_m3       = mod3_64(s1_x_reg);
        s1_a1       = s1_x_reg + (s1_x_reg << 2);
        s2_a2_next  = s1_a1 + (s1_a1 << 4);
        s2_v_next   = s1_v_reg && (s1_m3 != 2'd0);
        s2_odd_next = !s1_x_reg[0] && (s1_m3 == 2'd1);
        s2_unl_next = s1_below_reg && (!s1_rin_reg || (tbl_rd_data == ALL_ONES));
        s2_lim_next = s1_below_reg ? tbl_rd_data : range_limit;
    end

    // Stage two: doubled child and further product steps.
    always_comb
    begin
        s2_a3      = s2_a2_reg + (s2_a2_reg << 8);
        s3_a4_next = s2_a3 + (s2_a3 << 16);
        s2_z       = s2_x_reg << 1;
        s2_z_act   = (s2_z <= value_bound) && (s2_unl_reg || (s2_z < s2_lim_reg));
        if (s2_x_reg[VALUE_W-1])
        begin
            s3_zval_next  = '0;
            s3_zdisp_next = DISP_PRUNED;
        end
        else if (s2_z_act)
        begin
            s3_zval_next  = s2_z;
            s3_zdisp_next = DISP_ACTIVE;
        end
        else if (s2_z[VALUE_W-1])
        begin
            s3_zval_next  = '0;
            s3_zdisp_next = DISP_PRUNED;
        end
        else
        begin
            s3_zval_next  = s2_z;
            s3_zdisp_next = DISP_DEFERRED;
        end
    end

    // Stage three: (x - 1) / 3 as K - x * K modulo two to the sixty-fourth.
    always_comb
    begin
        s3_a5     = s3_a4_reg + (s3_a4_reg << 32);
        s4_y_next = THIRD_K - s3_a5;
    end

    // Stage four: odd child tests.
    always_comb
    begin
        s4_y_act         = (s4_y_reg <= value_bound) && (s4_unl_reg || (s4_y_reg < s4_lim_reg));
        brood.odd_valid  = s4_odd_reg && (s4_y_reg > 64'd1);
        brood.odd_value  = s4_y_reg;
        brood.odd_disp   = s4_y_act ? DISP_ACTIVE : DISP_DEFERRED;
        brood.even_value = s4_zval_reg;
        brood.even_disp  = s4_zdisp_reg;
        brood.depth      = s4_cd_reg;
    end

    assign brood_valid = s4_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_v_reg <= accept && (in_data.cmd == CMD_EXPAND);
            if (rdy2)
                s2_v_reg <= s2_v_next;
            if (rdy3)
                s3_v_reg <= s2_v_reg;
            if (rdy4)
                s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= in_data.node_value;
            s1_cd_reg    <= in_cd;
            s1_below_reg <= in_below;
            s1_rin_reg   <= in_rin;
        end
        if (rdy2)
        begin
            s2_x_reg   <= s1_x_reg;
            s2_cd_reg  <= s1_cd_reg;
            s2_odd_reg <= s2_odd_next;
            s2_a2_reg  <= s2_a2_next;
            s2_unl_reg <= s2_unl_next;
            s2_lim_reg <= s2_lim_next;
        end
        if (rdy3)
        begin
            s3_cd_reg    <= s2_cd_reg;
            s3_odd_reg   <= s2_odd_reg;
            s3_a4_reg    <= s3_a4_next;
            s3_unl_reg   <= s2_unl_reg;
            s3_lim_reg   <= s2_lim_reg;
            s3_zval_reg  <= s3_zval_next;
            s3_zdisp_reg <= s3_zdisp_next;
        end
        if (rdy4)
        begin
            s4_cd_reg    <= s3_cd_reg;
            s4_odd_reg   <= s3_odd_reg;
            s4_y_reg     <= s4_y_next;
            s4_unl_reg   <= s3_unl_reg;
            s4_lim_reg   <= s3_lim_reg;
            s4_zval_reg  <= s3_zval_reg;
            s4_zdisp_reg <= s3_zdisp_reg;
        end
    end

endmodule

// ----- rtl/core/icne_emit.sv -----
// Output register that delivers the odd child, when there is one, and then the doubled child of a node.
`timescale 1ns / 1ps

module icne_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 brood_valid,
    output logic                 brood_ready,
    input  icne_pkg::brood_t     brood,
    output logic                 out_valid,
    input  logic                 out_stall,
    output icne_pkg::out_item_t  out_data
);
    import icne_pkg::*;

    logic   e_v_reg;
    logic   e_v_next;
    logic   e_odd_reg;
    logic   e_odd_next;
    brood_t b_reg;
    logic   load;

    assign brood_ready = !e_v_reg || (!out_stall && !e_odd_reg);
    assign load        = brood_valid && brood_ready;

    always_comb
    begin
        e_v_next   = e_v_reg;
        e_odd_next = e_odd_reg;
        if (load)
        begin
            e_v_next   = 1'b1;
            e_odd_next = brood.odd_valid;
        end
        else if (e_v_reg && !out_stall)
        begin
            if (e_odd_reg)
                e_odd_next = 1'b0;
            else
                e_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg   <= 1'b0;
            e_odd_reg <= 1'b0;
        end
        else
        begin
            e_v_reg   <= e_v_next;
            e_odd_reg <= e_odd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            b_reg <= brood;
    end

    always_comb
    begin
        out_valid            = e_v_reg;
        out_data.child_depth = b_reg.depth;
        if (e_odd_reg)
        begin
            out_data.child_value = b_reg.odd_value;
            out_data.disposition = b_reg.odd_disp;
            out_data.last_child  = 1'b0;
        end
        else
        begin
            out_data.child_value = b_reg.even_value;
            out_data.disposition = b_reg.even_disp;
            out_data.last_child  = 1'b1;
        end
    end

endmodule

// ----- rtl/core/inverse_collatz_node_expander.sv -----
// Top level of the inverse-Collatz node expander: configuration registers and wiring.
// An accepted node passes the datapath stage registers and then the output register; a second child follows the first.
// One result leaves per cycle unless out_stall holds it; a node with two children gives its odd child first.
// Table loads and multiples of three are taken at the input and give no result.
// Reset returns the configuration registers to their defaults and empties the pipeline; the table holds nothing until loaded.
`timescale 1ns / 1ps

module inverse_collatz_node_expander #(
    parameter int unsigned TBL_DEPTH = icne_pkg::TBL_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  icne_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output icne_pkg::out_item_t          out_data,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [icne_pkg::VALUE_W-1:0] cfg_data
);
    import icne_pkg::*;

    localparam int unsigned AW = $clog2(TBL_DEPTH);

    logic [VALUE_W-1:0] range_limit_reg;
    logic [VALUE_W-1:0] range_limit_next;
    logic [VALUE_W-1:0] value_bound_reg;
    logic [VALUE_W-1:0] value_bound_next;
    logic [DEPTH_W-1:0] steps_bound_reg;
    logic [DEPTH_W-1:0] steps_bound_next;

    tbl_ctl_t           tbl_ctl;
    logic [AW-1:0]      tbl_wr_addr;
    logic [AW-1:0]      tbl_rd_addr;
    logic [VALUE_W-1:0] tbl_wr_data;
    logic [VALUE_W-1:0] tbl_rd_data;
    logic               brood_valid;
    logic               brood_ready;
    brood_t             brood;

    always_comb
    begin
        range_limit_next = range_limit_reg;
        value_bound_next = value_bound_reg;
        steps_bound_next = steps_bound_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_RANGE_LIMIT: range_limit_next = cfg_data;
                REG_VALUE_BOUND: value_bound_next = cfg_data;
                REG_STEPS_BOUND: steps_bound_next = cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= RANGE_LIMIT_RST;
            value_bound_reg <= '0;
            steps_bound_reg <= '0;
        end
        else
        begin
            range_limit_reg <= range_limit_next;
            value_bound_reg <= value_bound_next;
            steps_bound_reg <= steps_bound_next;
        end
    end

    icne_table #(
        .TBL_DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (clk),
        .ctl     (tbl_ctl),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    icne_datapath #(
        .TBL_DEPTH (TBL_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .range_limit (range_limit_reg),
        .value_bound (value_bound_reg),
        .steps_bound (steps_bound_reg),
        .tbl_ctl     (tbl_ctl),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .brood_valid (brood_valid),
        .brood       (brood),
        .brood_ready (brood_ready)
    );

    icne_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .brood_valid (brood_valid),
        .brood_ready (brood_ready),
        .brood       (brood),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ----- rtl/core/icne_checker.sv -----
// Port-level assertions for the inverse-Collatz node expander and their binding.
`timescale 1ns / 1ps

module icne_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input icne_pkg::out_item_t out_data
);
    import icne_pkg::*;

    // The pipeline is empty when reset is released.
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result item shown straight after reset");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

    // The second child follows the first without a gap.
    a_second_child: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_child |=> out_valid)
        else $error("gap between the children of one node");

    // Only the doubled child can be pruned, and then it carries a zero value.
    a_pruned_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.disposition == DISP_PRUNED)
        |-> out_data.last_child && (out_data.child_value == '0))
        else $error("pruned child malformed");

endmodule

bind inverse_collatz_node_expander icne_checker u_checker (.*);

// ----- dv/child_ledger_pkg.sv -----
// Scoreboard class that forecasts and checks the children of each expanded node.
`timescale 1ns / 1ps

package child_ledger_pkg;

    import icne_pkg::*;

    class child_ledger;

        logic [VALUE_W-1:0] range_limit = RANGE_LIMIT_RST;
        logic [VALUE_W-1:0] value_bound = '0;
        logic [DEPTH_W-1:0] steps_bound = '0;
        logic [VALUE_W-1:0] thresholds [TBL_DEPTH_DEF];
        bit                 loaded [TBL_DEPTH_DEF];
        out_item_t          expected_children [$];
        int unsigned        mismatches;

        function void write_reg(reg_idx_t idx, logic [VALUE_W-1:0] data);
            case (idx)
                REG_RANGE_LIMIT: range_limit = data;
                REG_VALUE_BOUND: value_bound = data;
                REG_STEPS_BOUND: steps_bound = data[DEPTH_W-1:0];
                default: ;
            endcase
        endfunction

        function bit child_is_active(logic [VALUE_W-1:0] z, logic [DEPTH_W-1:0] cdepth);
            logic [DEPTH_W-1:0] remaining;
            logic [VALUE_W-1:0] limit;
            if (z > value_bound)
                return 1'b0;
            if (cdepth < steps_bound)
            begin
                remaining = steps_bound - cdepth;
                limit = thresholds[remaining];
                if (limit != ALL_ONES && z >= limit)
                    return 1'b0;
            end
            else if (z >= range_limit)
            begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void expect_child(logic [VALUE_W-1:0] value, logic [DEPTH_W-1:0] depth,
                                   disp_t disp, logic last);
            out_item_t child;
            child.child_value = value;
            child.child_depth = depth;
            child.disposition = disp;
            child.last_child  = last;
            expected_children = {expected_children, child};
        endfunction

        function void note_node(in_item_t item);
            logic [DEPTH_W-1:0] cdepth;
            logic [VALUE_W-1:0] odd_child;
            logic [VALUE_W-1:0] doubled;
            cdepth = item.node_depth + 12'd1;
            if (item.cmd == CMD_LOAD)
            begin
                thresholds[item.node_depth] = item.table_word;
                loaded[item.node_depth] = 1'b1;
                return;
            end
            if ((item.node_value % 64'd3) == 64'd0)
                return;
            if ((item.node_value % 64'd6) == 64'd4)
            begin
                odd_child = (item.node_value - 64'd1) / 64'd3;
                if (odd_child > 64'd1)
                begin
                    if (child_is_active(odd_child, cdepth))
                        expect_child(odd_child, cdepth, DISP_ACTIVE, 1'b0);
                    else
                        expect_child(odd_child, cdepth, DISP_DEFERRED, 1'b0);
                end
            end
            if (item.node_value[VALUE_W-1])
            begin
                expect_child('0, cdepth, DISP_PRUNED, 1'b1);
                return;
            end
            doubled = item.node_value << 1;
            if (child_is_active(doubled, cdepth))
                expect_child(doubled, cdepth, DISP_ACTIVE, 1'b1);
            else if (doubled[VALUE_W-1])
                expect_child('0, cdepth, DISP_PRUNED, 1'b1);
            else
                expect_child(doubled, cdepth, DISP_DEFERRED, 1'b1);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", what);
        endfunction

        function void check_child(out_item_t got);
            out_item_t want;
            if (expected_children.size() == 0)
            begin
                flag($sformatf("unexpected child: value %h depth %0d disp %0d last %0d",
                               got.child_value, got.child_depth, got.disposition,
                               got.last_child));
                return;
            end
            want = expected_children.pop_front();
            if (got.child_value !== want.child_value || got.child_depth !== want.child_depth ||
                got.disposition !== want.disposition || got.last_child !== want.last_child)
                flag($sformatf({"child mismatch: expected value %h depth %0d disp %0d last %0d,",
                                " got value %h depth %0d disp %0d last %0d"},
                               want.child_value, want.child_depth, want.disposition,
                               want.last_child, got.child_value, got.child_depth,
                               got.disposition, got.last_child));
        endfunction

    endclass

endpackage

// ----- dv/testbench.sv -----
// Top-level testbench of the inverse-Collatz node expander with directed and random stimulus and stalls.
`timescale 1ns / 1ps

module testbench;

    import icne_pkg::*;
    import child_ledger_pkg::*;

    localparam int unsigned IDLE_LIMIT      = 4000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned PHASES          = 12;
    localparam int unsigned ITEMS_PER_PHASE = 90;
    localparam logic [VALUE_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] TOP_HALF = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = REG_RANGE_LIMIT;
    logic [VALUE_W-1:0]   cfg_data  = '0;

    child_ledger ledger = new();
    bit          tx_calm;
    int unsigned rx_hold;
    int unsigned rx_calm;
    int unsigned idle_cycles;

    inverse_collatz_node_expander dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [VALUE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_W-1:0] scaled64();
        return rand64() >> $urandom_range(0, 63);
    endfunction

    function automatic int unsigned idle_len();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        if (sel < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_threshold();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return ALL_ONES;
        if (sel < 20)
            return '0;
        return scaled64();
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            v = SIGN_BIT - 64'd24 + 64'($urandom_range(0, 48));
        else if (sel < 20)
            v = rand64();
        else
            v = scaled64();
        if ($urandom_range(0, 99) < 60)
            v = v - (v % 64'd6) + 64'd4;
        return v;
    endfunction

    function automatic logic [DEPTH_W-1:0] pick_depth();
        logic [DEPTH_W-1:0] d;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            d = ledger.steps_bound - 12'($urandom_range(0, 8));
        else if (sel < 85)
            d = 12'($urandom_range(0, 4094));
        else
            d = ledger.steps_bound + 12'($urandom_range(0, 4));
        if (d == 12'hFFF)
            d = 12'hFFE;
        return d;
    endfunction

    task automatic drive_item(in_item_t item);
        int unsigned gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        ledger.note_node(item);
    endtask

    task automatic load_entry(logic [DEPTH_W-1:0] idx, logic [VALUE_W-1:0] word);
        in_item_t item;
        item.cmd        = CMD_LOAD;
        item.node_value = rand64();
        item.node_depth = idx;
        item.table_word = word;
        drive_item(item);
    endtask

    task automatic expand_node(logic [VALUE_W-1:0] value, logic [DEPTH_W-1:0] depth);
        in_item_t item;
        logic [DEPTH_W-1:0] cdepth;
        cdepth = depth + 12'd1;
        if (cdepth < ledger.steps_bound && !ledger.loaded[ledger.steps_bound - cdepth])
            load_entry(ledger.steps_bound - cdepth, pick_threshold());
        item.cmd        = CMD_EXPAND;
        item.node_value = value;
        item.node_depth = depth;
        item.table_word = rand64();
        drive_item(item);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.expected_children.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [VALUE_W-1:0] limit, logic [VALUE_W-1:0] bound,
                             logic [DEPTH_W-1:0] steps);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RANGE_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        ledger.write_reg(REG_RANGE_LIMIT, limit);
        cfg_index <= REG_VALUE_BOUND;
        cfg_data  <= bound;
        @(posedge clk);
        ledger.write_reg(REG_VALUE_BOUND, bound);
        cfg_index <= REG_STEPS_BOUND;
        cfg_data  <= {52'h0, steps};
        @(posedge clk);
        ledger.write_reg(REG_STEPS_BOUND, {52'h0, steps});
        cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        configure(64'd1 << 20, ALL_ONES, 12'd4);
        load_entry(12'd1, ALL_ONES);
        load_entry(12'd2, '0);
        load_entry(12'd3, 64'd1000);
        load_entry(12'd4, TOP_HALF);
        load_entry(12'd0, rand64());
        load_entry(12'd4095, rand64());
        expand_node(64'd0, 12'd0);
        expand_node(64'd3, 12'd7);
        expand_node(64'd1, 12'd9);
        expand_node(64'd4, 12'd9);
        expand_node(64'd10, 12'd9);
        expand_node(64'd16, 12'd0);
        expand_node(64'd10, 12'd1);
        expand_node(TOP_HALF, 12'd2);
        expand_node(TOP_HALF, 12'd5);
        expand_node(64'h4000_0000_0000_0000, 12'd9);
        expand_node(SIGN_BIT, 12'd9);
        expand_node(64'hFFFF_FFFF_FFFF_FFFA, 12'd9);
        expand_node(ALL_ONES, 12'd4094);
        expand_node(64'd10, 12'd4095);
        expand_node(64'd10, 12'd4094);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            ledger.check_child(out_data);
        if (rx_hold != 0)
        begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else if (rx_calm != 0)
        begin
            rx_calm--;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            rx_calm = $urandom_range(20, 200);
            out_stall <= 1'b0;
        end
        else
        begin
            rx_hold = idle_len();
            out_stall <= (rx_hold != 0);
            if (rx_hold != 0)
                rx_hold--;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned        p;
        int unsigned        n;
        logic [VALUE_W-1:0] limit;
        logic [VALUE_W-1:0] bound;
        logic [DEPTH_W-1:0] steps;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        tx_calm = 1'b0;
        run_directed();
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: configure('0, '0, 12'd0);
                1: configure(ALL_ONES, ALL_ONES, 12'd4095);
                2: configure(ALL_ONES, ALL_ONES, 12'd0);
                3: configure(RANGE_LIMIT_RST, scaled64(), 12'd1);
                default:
                begin
                    limit = ($urandom_range(0, 9) == 0) ? ALL_ONES : scaled64();
                    bound = ($urandom_range(0, 4) == 0) ? ALL_ONES : scaled64();
                    if ($urandom_range(0, 1) == 0)
                        steps = 12'($urandom_range(0, 40));
                    else
                        steps = 12'($urandom_range(0, 4095));
                    configure(limit, bound, steps);
                end
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    if ($urandom_range(0, 1) == 0)
                        load_entry(ledger.steps_bound - 12'($urandom_range(0, 8)),
                                   pick_threshold());
                    else
                        load_entry(12'($urandom_range(0, 4095)), pick_threshold());
                end
                else
                begin
                    expand_node(pick_value(), pick_depth());
                end
            end
            drain();
        end
        repeat (20) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.expected_children.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/icne_pkg.sv
rtl/core/icne_table.sv
rtl/core/icne_datapath.sv
rtl/core/icne_emit.sv
rtl/core/inverse_collatz_node_expander.sv
rtl/core/icne_checker.sv
dv/child_ledger_pkg.sv
dv/testbench.sv
